[hdl/owrs_pkg.sv]
`timescale 1ns / 1ps

package owrs_pkg;

  localparam int unsigned RomBits = 64;
  localparam int unsigned PosW    = 7;
  localparam int unsigned IdxW    = 6;

  localparam logic [7:0] CmdNormal      = 8'hF0;
  localparam logic [7:0] CmdConditional = 8'hEC;

  typedef enum logic [1:0] {
    OP_RESET  = 2'd0,
    OP_TARGET = 2'd1,
    OP_START  = 2'd2,
    OP_PAIR   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DIR  = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] family_byte;
    logic       presence;
    logic       search_mode;
    logic       id_bit;
    logic       complement_bit;
  } item_t;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          command_byte;
    logic                direction;
    logic                found;
    logic [RomBits-1:0]  rom_address;
    logic                last_device;
  } result_t;

endpackage

[hdl/owrs_core.sv]
`timescale 1ns / 1ps

module owrs_core
  import owrs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  output logic    has_res_o,
  output result_t res_o
);

  logic [RomBits-1:0] rom_q, rom_d;
  logic [PosW-1:0]    prior_q, prior_d;
  logic               done_q, done_d;
  logic [PosW-1:0]    bitpos_q, bitpos_d;
  logic [PosW-1:0]    newest_q, newest_d;
  logic               active_q, active_d;

  logic [PosW-1:0]    pos;
  logic [IdxW-1:0]    idx;
  logic               dir;
  logic               tie;
  logic [RomBits-1:0] rom_upd;
  logic [PosW-1:0]    newest_upd;

  // Bit slot handling shared by all pair items.
  always_comb begin
    if (bitpos_q == '0 || bitpos_q > PosW'(RomBits)) begin
      pos = PosW'(RomBits);
    end else begin
      pos = bitpos_q;
    end
    idx = IdxW'(pos - PosW'(1));
    tie = (item_i.id_bit == item_i.complement_bit);
    if (!tie) begin
      dir = item_i.id_bit;
    end else if (pos < prior_q) begin
      dir = rom_q[idx];
    end else begin
      dir = (pos == prior_q);
    end
    rom_upd      = rom_q;
    rom_upd[idx] = dir;
    newest_upd   = (tie && !dir) ? pos : newest_q;
  end

  always_comb begin
    rom_d     = rom_q;
    prior_d   = prior_q;
    done_d    = done_q;
    bitpos_d  = bitpos_q;
    newest_d  = newest_q;
    active_d  = active_q;
    has_res_o = 1'b0;
    res_o     = '0;
    res_o.kind = KIND_DONE;

    case (item_i.opcode)
      OP_RESET: begin
        rom_d    = '0;
        prior_d  = '0;
        done_d   = 1'b0;
        bitpos_d = PosW'(1);
        newest_d = '0;
        active_d = 1'b0;
      end
      OP_TARGET: begin
        rom_d    = RomBits'(item_i.family_byte);
        prior_d  = PosW'(RomBits);
        done_d   = 1'b0;
        bitpos_d = PosW'(1);
        newest_d = '0;
        active_d = 1'b0;
      end
      OP_START: begin
        bitpos_d  = PosW'(1);
        newest_d  = '0;
        has_res_o = 1'b1;
        if (done_q || !item_i.presence) begin
          prior_d    = '0;
          done_d     = 1'b0;
          active_d   = 1'b0;
          res_o.kind = KIND_DONE;
        end else begin
          active_d           = 1'b1;
          res_o.kind         = KIND_CMD;
          res_o.command_byte = item_i.search_mode ? CmdConditional : CmdNormal;
        end
      end
      OP_PAIR: begin
        if (active_q) begin
          has_res_o = 1'b1;
          if (item_i.id_bit && item_i.complement_bit) begin
            // Nobody answered the slot.
            active_d   = 1'b0;
            prior_d    = '0;
            done_d     = 1'b0;
            res_o.kind = KIND_DONE;
          end else begin
            rom_d           = rom_upd;
            newest_d        = newest_upd;
            res_o.direction = dir;
            if (pos < PosW'(RomBits)) begin
              bitpos_d   = pos + PosW'(1);
              res_o.kind = KIND_DIR;
            end else begin
              active_d   = 1'b0;
              bitpos_d   = PosW'(RomBits + 1);
              res_o.kind = KIND_DONE;
              if (rom_upd[7:0] == 8'd0) begin
                // A zero family byte is not a real device.
                prior_d = '0;
                done_d  = 1'b0;
              end else begin
                prior_d           = newest_upd;
                done_d            = done_q || (newest_upd == '0);
                res_o.found       = 1'b1;
                res_o.rom_address = rom_upd;
                res_o.last_device = done_q || (newest_upd == '0);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q    <= '0;
      prior_q  <= '0;
      done_q   <= 1'b0;
      bitpos_q <= PosW'(1);
      newest_q <= '0;
      active_q <= 1'b0;
    end else if (step_i) begin
      rom_q    <= rom_d;
      prior_q  <= prior_d;
      done_q   <= done_d;
      bitpos_q <= bitpos_d;
      newest_q <= newest_d;
      active_q <= active_d;
    end
  end

endmodule

[hdl/onewire_rom_search_engine_top.sv]
`timescale 1ns / 1ps
// Path: an input transaction is held in the input register, and its result, if any,
// is then held in the result register.
// Throughput: one item per cycle; the input register advances whenever the result
// register is empty or being taken, so both sides can stream without gaps.
// Reset: rst_ni clears the search state (ROM, discrepancy marks, bit position) and
// both stage valids at once; no clearing pass is needed.

module onewire_rom_search_engine_top
  import owrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // family_byte[7:0], presence[8], search_mode[9], id_bit[10], complement_bit[11]
  input  logic [15:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // command_byte[7:0], direction[8], found[9], rom_address[73:10], last_device[74]
  output logic [79:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser
);

  item_t   item_q;
  logic    in_valid_q;
  result_t out_q;
  logic    out_valid_q;
  logic    out_free;
  logic    step;
  logic    has_res;
  result_t res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.opcode         <= opcode_e'(s_axis_tuser);
      item_q.family_byte    <= s_axis_tdata[7:0];
      item_q.presence       <= s_axis_tdata[8];
      item_q.search_mode    <= s_axis_tdata[9];
      item_q.id_bit         <= s_axis_tdata[10];
      item_q.complement_bit <= s_axis_tdata[11];
    end
  end

  owrs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (item_q),
    .has_res_o (has_res),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= has_res;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && has_res) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {5'b0, out_q.last_device, out_q.rom_address, out_q.found,
                          out_q.direction, out_q.command_byte};

endmodule

[hdl/owrs_checker.sv]
`timescale 1ns / 1ps

module owrs_checker
  import owrs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only a done transaction may report a device, and that device has a family byte.
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |->
      m_axis_tuser == KIND_DONE && m_axis_tdata[17:10] != 8'd0)
    else $error("found without a done transaction or with zero family");

  // The last-device mark comes only with a found device.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[74] |-> m_axis_tdata[9])
    else $error("last device without found");

  // Command transactions carry one of the two search commands and nothing else.
  a_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_CMD |->
      (m_axis_tdata[7:0] == CmdNormal || m_axis_tdata[7:0] == CmdConditional) &&
      m_axis_tdata[79:8] == '0)
    else $error("bad command transaction");

endmodule

bind onewire_rom_search_engine_top owrs_checker u_owrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench
  import owrs_pkg::*;
;

  localparam int unsigned FamilyLimit = 9;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  onewire_rom_search_engine_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted search state.
  logic [63:0] srch_rom = '0;
  logic [6:0]  srch_last_disc = '0;
  logic [3:0]  srch_family_disc = '0;
  logic        srch_all_found = 1'b0;
  logic [6:0]  srch_bit_pos = 7'd1;
  logic [6:0]  srch_last_zero = '0;
  logic        srch_running = 1'b0;

  result_t     search_results_due[$];
  kind_e       step_kind;
  logic        step_dir;
  bit          burst_mode = 1'b0;
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic clear_search_marks();
    srch_last_disc   = '0;
    srch_all_found   = 1'b0;
    srch_family_disc = '0;
  endtask

  task automatic predict_search_item(input item_t it);
    result_t    res;
    logic [6:0] pos;
    logic       dir;
    bit         emitted;
    res = '0;
    dir = 1'b0;
    emitted = 1'b0;
    case (it.opcode)
      OP_RESET: begin
        clear_search_marks();
        srch_rom       = '0;
        srch_running   = 1'b0;
        srch_bit_pos   = 7'd1;
        srch_last_zero = '0;
      end
      OP_TARGET: begin
        srch_rom         = {56'd0, it.family_byte};
        srch_last_disc   = 7'(RomBits);
        srch_family_disc = '0;
        srch_all_found   = 1'b0;
        srch_running     = 1'b0;
        srch_bit_pos     = 7'd1;
        srch_last_zero   = '0;
      end
      OP_START: begin
        srch_bit_pos   = 7'd1;
        srch_last_zero = '0;
        emitted = 1'b1;
        if (srch_all_found || !it.presence) begin
          clear_search_marks();
          srch_running = 1'b0;
          res.kind = KIND_DONE;
        end else begin
          srch_running = 1'b1;
          res.kind = KIND_CMD;
          res.command_byte = it.search_mode ? CmdConditional : CmdNormal;
        end
      end
      default: begin
        if (srch_running) begin
          emitted = 1'b1;
          if (it.id_bit && it.complement_bit) begin
            // Nobody pulled the bus low in either slot: no device is left.
            srch_running = 1'b0;
            clear_search_marks();
            res.kind = KIND_DONE;
          end else begin
            pos = srch_bit_pos;
            if (pos == 0 || pos > RomBits) begin
              pos = 7'(RomBits);
            end
            if (it.id_bit != it.complement_bit) begin
              dir = it.id_bit;
            end else begin
              if (pos < srch_last_disc) begin
                dir = srch_rom[pos - 1];
              end else begin
                dir = (pos == srch_last_disc);
              end
              if (!dir) begin
                srch_last_zero = pos;
                if (pos < FamilyLimit) begin
                  srch_family_disc = pos[3:0];
                end
              end
            end
            srch_rom[pos - 1] = dir;
            res.direction = dir;
            if (pos < RomBits) begin
              srch_bit_pos = pos + 7'd1;
              res.kind = KIND_DIR;
            end else begin
              srch_running   = 1'b0;
              srch_bit_pos   = 7'(RomBits + 1);
              srch_last_disc = srch_last_zero;
              if (srch_last_disc == 0) begin
                srch_all_found = 1'b1;
              end
              res.kind = KIND_DONE;
              // A ROM with a zero family byte does not count as a device.
              if (srch_rom[7:0] == 8'h00) begin
                clear_search_marks();
              end else begin
                res.found = 1'b1;
                res.rom_address = srch_rom;
                res.last_device = srch_all_found;
              end
            end
          end
        end
      end
    endcase
    if (emitted) begin
      search_results_due.push_back(res);
    end
    step_kind = emitted ? res.kind : KIND_CMD;
    step_dir  = dir;
  endtask

  task automatic push_search_item(input opcode_e op, input logic [7:0] fam, input logic pres,
                                  input logic mode, input logic idb, input logic cmpb);
    item_t       it;
    int unsigned gap;
    it.opcode         = op;
    it.family_byte    = fam;
    it.presence       = pres;
    it.search_mode    = mode;
    it.id_bit         = idb;
    it.complement_bit = cmpb;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, cmpb, idb, mode, pres, fam};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_search_item(it);
    items_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (search_results_due.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stall before each transaction.
  initial begin
    int unsigned stall;
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      report_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (search_results_due.size() == 0) begin
        report_failure($sformatf("unexpected result, kind %0d", m_axis_tuser));
      end else begin
        want = search_results_due.pop_front();
        check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
        check_field("command_byte", 64'(want.command_byte), 64'(m_axis_tdata[7:0]));
        check_field("direction", 64'(want.direction), 64'(m_axis_tdata[8]));
        check_field("found", 64'(want.found), 64'(m_axis_tdata[9]));
        check_field("rom_address", want.rom_address, m_axis_tdata[73:10]);
        check_field("last_device", 64'(want.last_device), 64'(m_axis_tdata[74]));
      end
    end
  end

  // Short hand-picked sequences around start, idle pairs, aborted passes, targets and resets.
  task automatic test_directed_cases();
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_PAIR, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
    push_search_item(OP_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_START, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_START, 8'h5A, 1'b1, 1'b1, 1'b0, 1'b0);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_TARGET, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_START, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_TARGET, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_START, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_search_item(OP_RESET, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
    push_search_item(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
  endtask

  // Enumerates a simulated bus population: each pair is the wired-AND of the
  // devices still taking part, and devices drop out on a direction they do not match.
  task automatic run_search_session(input int unsigned ndev, input bit zero_family);
    logic [63:0] roms[$];
    bit          alive[$];
    logic [7:0]  shared_family;
    logic [7:0]  seed_family;
    logic        idb;
    logic        cmpb;
    logic        pres;
    int unsigned pass_no;
    int unsigned b;
    int unsigned k;
    int unsigned break_at;
    opcode_e     pick;
    bit          broke;
    shared_family = 8'($urandom_range(0, 255));
    for (k = 0; k < ndev; k++) begin
      roms.push_back({$urandom, $urandom});
      if ($urandom_range(0, 1) == 1) begin
        roms[k][7:0] = shared_family;
      end
      alive.push_back(1'b1);
    end
    if (zero_family && ndev != 0) begin
      roms[0][7:0] = 8'h00;
    end
    if ($urandom_range(0, 3) == 0) begin
      seed_family = 8'($urandom_range(0, 255));
      if (ndev != 0 && $urandom_range(0, 1) == 1) begin
        seed_family = roms[$urandom_range(0, ndev - 1)][7:0];
      end
      push_search_item(OP_TARGET, seed_family, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
    end else begin
      push_search_item(OP_RESET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
    end
    broke = 1'b0;
    for (pass_no = 0; pass_no < ndev + 2 && !broke; pass_no++) begin
      pres = (ndev != 0);
      if ($urandom_range(0, 15) == 0) begin
        pres = !pres;
      end
      push_search_item(OP_START, 8'($urandom_range(0, 255)), pres, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if (step_kind == KIND_DONE) begin
        break;
      end
      for (k = 0; k < ndev; k++) begin
        alive[k] = 1'b1;
      end
      break_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 63) : 64;
      for (b = 0; b < 64; b++) begin
        if (b == break_at) begin
          // Disturb the pass with a restart, a reset, a target or a dead bus.
          pick = opcode_e'($urandom_range(0, 3));
          if (pick == OP_PAIR) begin
            push_search_item(OP_PAIR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'b1, 1'b1);
          end else begin
            push_search_item(pick, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
          end
          broke = 1'b1;
          break;
        end
        idb  = 1'b1;
        cmpb = 1'b1;
        for (k = 0; k < ndev; k++) begin
          if (alive[k]) begin
            idb  = idb & roms[k][b];
            cmpb = cmpb & !roms[k][b];
          end
        end
        push_search_item(OP_PAIR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), idb, cmpb);
        if (step_kind != KIND_DIR) begin
          break;
        end
        for (k = 0; k < ndev; k++) begin
          if (roms[k][b] != step_dir) begin
            alive[k] = 1'b0;
          end
        end
      end
    end
  endtask

  task automatic test_basic_searches();
    run_search_session(1, 1'b0);
    run_search_session(1, 1'b1);
    run_search_session(0, 1'b0);
    run_search_session(3, 1'b0);
  endtask

  task automatic test_random_searches();
    int unsigned ndev;
    while (items_sent < 1150) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      ndev = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
      run_search_session(ndev, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) == 0) begin
        wait_for_results();
      end
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_random_noise();
    int unsigned n;
    for (n = 0; n < 150; n++) begin
      push_search_item(opcode_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    wait_for_results();
    test_basic_searches();
    wait_for_results();
    test_random_searches();
    test_random_noise();
    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (search_results_due.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", search_results_due.size()));
    end
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
